// ===== hdl/lps_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lps_pkg
// Shared constants, types and controller/datapath links for the longest
// palindromic subsequence core.
// ============================================================================
package lps_pkg;

    // String capacity and derived widths
    localparam int MAX_LEN   = 64;
    localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int LEN_W     = CNT_W;
    localparam int TBL_AW    = 2 * ADDR_W;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW_START,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_RB_INIT,
        ST_RB_TOTAL_RD,
        ST_RB_TOTAL,
        ST_RB_RD,
        ST_RB_STEP,
        ST_OUT_RD,
        ST_OUT_EMIT
    } lps_state_t;

    // Which addresses the memories are read at
    typedef enum logic [1:0] {
        ADDR_FILL,
        ADDR_TOTAL,
        ADDR_RB
    } addr_mode_t;

    typedef struct packed {
        logic       load;       // store incoming byte
        logic       row_init;   // write diagonal, start row
        logic       next_row;   // step row index down
        logic       cell_wr;    // write one table cell
        logic       rb_init;    // start rebuild
        logic       rb_total;   // capture palindrome length
        logic       rb_step;    // one rebuild step
        logic       out_next;   // advance output index
        logic       clear;      // end of string
        addr_mode_t addr_mode;
    } lps_cmd_t;

    typedef struct packed {
        logic full;
        logic row_last;
        logic cell_last;
        logic i_zero;
        logic rb_finish;
        logic out_last;
    } lps_status_t;

endpackage

// ===== hdl/lps_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lps_ctrl
// Sequencer: byte loading, table fill, rebuild and result emission.
// ============================================================================
module lps_ctrl
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_last,
    input  lps_status_t status,
    output lps_cmd_t    cmd,
    output logic        busy,
    output logic        result_strobe
);

    lps_state_t state_reg;
    lps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.addr_mode = ADDR_FILL;
        busy          = 1'b1;
        result_strobe = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_ROW_START;
                    end
                end
            end
            ST_ROW_START:
            begin
                cmd.row_init = 1'b1;
                if (status.row_last)
                begin
                    if (status.i_zero)
                    begin
                        state_next = ST_RB_INIT;
                    end
                    else
                    begin
                        cmd.next_row = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_CELL_RD:
            begin
                state_next = ST_CELL_WR;
            end
            ST_CELL_WR:
            begin
                cmd.cell_wr = 1'b1;
                if (status.cell_last)
                begin
                    if (status.i_zero)
                    begin
                        state_next = ST_RB_INIT;
                    end
                    else
                    begin
                        cmd.next_row = 1'b1;
                        state_next   = ST_ROW_START;
                    end
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_RB_INIT:
            begin
                cmd.rb_init = 1'b1;
                state_next  = ST_RB_TOTAL_RD;
            end
            ST_RB_TOTAL_RD:
            begin
                cmd.addr_mode = ADDR_TOTAL;
                state_next    = ST_RB_TOTAL;
            end
            ST_RB_TOTAL:
            begin
                cmd.rb_total = 1'b1;
                state_next   = ST_RB_RD;
            end
            ST_RB_RD:
            begin
                cmd.addr_mode = ADDR_RB;
                state_next    = ST_RB_STEP;
            end
            ST_RB_STEP:
            begin
                cmd.addr_mode = ADDR_RB;
                cmd.rb_step   = 1'b1;
                state_next    = status.rb_finish ? ST_OUT_RD : ST_RB_RD;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                result_strobe = 1'b1;
                cmd.out_next  = 1'b1;
                if (status.out_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lps_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lps_datapath
// Text store, length table, half-palindrome buffer and index registers.
// ============================================================================
module lps_datapath
    import lps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        char_in,
    input  lps_cmd_t          cmd,
    output lps_status_t       status,
    output logic [LEN_W-1:0]  pal_length,
    output logic [ADDR_W-1:0] position,
    output logic [7:0]        pal_char,
    output logic              last_out,
    output logic              truncated
);

    // memories
    logic [7:0]       text_mem [MAX_LEN];
    logic [LEN_W-1:0] tbl_mem  [TBL_DEPTH];
    logic [7:0]       pbuf_mem [MAX_LEN];

    logic [7:0]       text_a_reg;
    logic [7:0]       text_b_reg;
    logic [LEN_W-1:0] tbl_rd0_reg;
    logic [LEN_W-1:0] tbl_rd1_reg;
    logic [7:0]       pbuf_rd_reg;

    // control and index registers
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] left_reg;
    logic [ADDR_W-1:0] right_reg;
    logic [LEN_W-1:0]  d_reg;      // L[i+1][j-1]
    logic [LEN_W-1:0]  lv_reg;     // L[i][j-1]
    logic [LEN_W-1:0]  total_reg;
    logic [CNT_W-1:0]  pl_reg;
    logic [ADDR_W-1:0] k_reg;

    logic [ADDR_W-1:0] text_a_addr;
    logic [ADDR_W-1:0] text_b_addr;
    logic [TBL_AW-1:0] tbl_raddr0;
    logic [TBL_AW-1:0] tbl_raddr1;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [LEN_W-1:0]  tbl_wdata;
    logic              tbl_we;
    logic [ADDR_W-1:0] pbuf_raddr;
    logic [LEN_W-1:0]  cell_val;
    logic [LEN_W-1:0]  mirror;
    logic              ends_match;

    assign ends_match = (text_a_reg == text_b_reg);
    assign cell_val   = ends_match ? (d_reg + LEN_W'(2))
                      : ((tbl_rd0_reg >= lv_reg) ? tbl_rd0_reg : lv_reg);

    always_comb
    begin
        text_a_addr = i_reg;
        text_b_addr = j_reg;
        tbl_raddr0  = {i_reg + ADDR_W'(1), j_reg};
        case (cmd.addr_mode)
            ADDR_FILL:
            begin
                text_a_addr = i_reg;
                text_b_addr = j_reg;
                tbl_raddr0  = {i_reg + ADDR_W'(1), j_reg};
            end
            ADDR_TOTAL:
            begin
                text_a_addr = left_reg;
                text_b_addr = right_reg;
                tbl_raddr0  = {left_reg, right_reg};
            end
            ADDR_RB:
            begin
                text_a_addr = left_reg;
                text_b_addr = right_reg;
                tbl_raddr0  = {left_reg + ADDR_W'(1), right_reg};
            end
            default:
            begin
                text_a_addr = i_reg;
                text_b_addr = j_reg;
                tbl_raddr0  = {i_reg + ADDR_W'(1), j_reg};
            end
        endcase
    end

    assign tbl_raddr1 = {left_reg, right_reg - ADDR_W'(1)};
    assign tbl_we     = cmd.row_init | cmd.cell_wr;
    assign tbl_waddr  = cmd.row_init ? {i_reg, i_reg} : {i_reg, j_reg};
    assign tbl_wdata  = cmd.row_init ? LEN_W'(1) : cell_val;

    // right half of the palindrome mirrors the stored left half
    assign mirror     = total_reg - LEN_W'(1) - LEN_W'(k_reg);
    assign pbuf_raddr = (CNT_W'(k_reg) < pl_reg) ? k_reg : mirror[ADDR_W-1:0];

    // text store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load && !status.full)
        begin
            text_mem[count_reg[ADDR_W-1:0]] <= char_in;
        end
        text_a_reg <= text_mem[text_a_addr];
        text_b_reg <= text_mem[text_b_addr];
    end

    // length table: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd0_reg <= tbl_mem[tbl_raddr0];
        tbl_rd1_reg <= tbl_mem[tbl_raddr1];
    end

    // half-palindrome buffer
    always_ff @(posedge clk)
    begin
        if (cmd.rb_step && ((left_reg == right_reg) || ends_match))
        begin
            pbuf_mem[pl_reg[ADDR_W-1:0]] <= text_a_reg;
        end
        pbuf_rd_reg <= pbuf_mem[pbuf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (status.full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // last row index of the string once this byte is in
            i_reg <= status.full ? ADDR_W'(MAX_LEN - 1) : count_reg[ADDR_W-1:0];
        end
        if (cmd.row_init)
        begin
            j_reg  <= i_reg + ADDR_W'(1);
            d_reg  <= '0;
            lv_reg <= LEN_W'(1);
        end
        if (cmd.next_row)
        begin
            i_reg <= i_reg - ADDR_W'(1);
        end
        if (cmd.cell_wr)
        begin
            d_reg  <= tbl_rd0_reg;
            lv_reg <= cell_val;
            j_reg  <= j_reg + ADDR_W'(1);
        end
        if (cmd.rb_init)
        begin
            left_reg  <= '0;
            right_reg <= ADDR_W'(count_reg - CNT_W'(1));
            pl_reg    <= '0;
            k_reg     <= '0;
        end
        if (cmd.rb_total)
        begin
            total_reg <= tbl_rd0_reg;
        end
        if (cmd.rb_step)
        begin
            if (left_reg == right_reg)
            begin
                pl_reg <= pl_reg + CNT_W'(1);
            end
            else if (ends_match)
            begin
                pl_reg    <= pl_reg + CNT_W'(1);
                left_reg  <= left_reg + ADDR_W'(1);
                right_reg <= right_reg - ADDR_W'(1);
            end
            else if (tbl_rd0_reg >= tbl_rd1_reg)
            begin
                left_reg <= left_reg + ADDR_W'(1);
            end
            else
            begin
                right_reg <= right_reg - ADDR_W'(1);
            end
        end
        if (cmd.out_next)
        begin
            k_reg <= k_reg + ADDR_W'(1);
        end
    end

    assign status.full      = (count_reg == CNT_W'(MAX_LEN));
    assign status.row_last  = ((CNT_W'(i_reg) + CNT_W'(1)) == count_reg);
    assign status.cell_last = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign status.i_zero    = (i_reg == '0);
    assign status.rb_finish = (left_reg == right_reg)
                            || (ends_match
                                && ((CNT_W'(left_reg) + CNT_W'(1)) == CNT_W'(right_reg)));
    assign status.out_last  = ((LEN_W'(k_reg) + LEN_W'(1)) == total_reg);

    assign pal_length = total_reg;
    assign position   = k_reg;
    assign pal_char   = pbuf_rd_reg;
    assign last_out   = status.out_last;
    assign truncated  = ovf_reg;

    // cell writes only ever land above the diagonal
    a_cell_above_diag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_wr |-> (j_reg > i_reg))
        else $error("table cell written on or below diagonal");

    // rebuild window never crosses over
    a_rb_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rb_step |-> (left_reg <= right_reg))
        else $error("rebuild step with empty window");

    // no emission past the palindrome length
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_next |-> ((total_reg != '0) && (LEN_W'(k_reg) < total_reg)))
        else $error("result index beyond palindrome length");

    // byte count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("byte count beyond capacity");

    // a dropped byte always flags truncation
    a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.full && !cmd.clear) |=> ovf_reg)
        else $error("dropped byte not flagged");

endmodule

// ===== hdl/longest_palindromic_subsequence_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// longest_palindromic_subsequence_core
// Longest palindromic subsequence of a byte string, with one palindrome
// rebuilt and streamed out a byte at a time.
// ============================================================================
// Bytes are taken one per cycle while busy is low (start high, busy low).
// Up to MAX_LEN (64) bytes are kept; further bytes are dropped and every
// result of that string carries truncated. The byte with is_last set (kept or
// dropped) starts the work and busy stays high until the last result is out.
// For a string of n kept bytes the work after the last byte runs in order:
// the table fill (a row start per row, then per cell a registered read of
// the previous row and the write through the single table write port), the
// rebuild set-up (ST_RB_INIT, ST_RB_TOTAL_RD, ST_RB_TOTAL) that reads the
// palindrome length, at most n rebuild steps, each a table read and then the
// step, and each result as a buffer read, then emission. Results appear on
// pal_length, position, pal_char, last_out and truncated for exactly one
// cycle while result_strobe is high; there is no backpressure, so the
// receiver must take each one as it comes. No clearing pass is needed after
// reset; the block takes bytes at once.
// ============================================================================
module longest_palindromic_subsequence_core
    import lps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [7:0]        char_in,
    input  logic              is_last,
    output logic              busy,
    output logic              result_strobe,
    output logic [LEN_W-1:0]  pal_length,
    output logic [ADDR_W-1:0] position,
    output logic [7:0]        pal_char,
    output logic              last_out,
    output logic              truncated
);

    lps_cmd_t    cmd;
    lps_status_t status;

    // sequencer: load, fill, rebuild, emit
    lps_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .is_last       (is_last),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    // storage, table arithmetic and result registers
    lps_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .cmd        (cmd),
        .status     (status),
        .pal_length (pal_length),
        .position   (position),
        .pal_char   (pal_char),
        .last_out   (last_out),
        .truncated  (truncated)
    );

endmodule
